>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define PFSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PFSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pfse_pkg.sv
// types, constants and key square lookup functions of the playfair encrypter
// no dependencies; used by playfair_stream_encrypter and tb
`default_nettype none

package pfse_pkg;

  // ascii and letter code constants
  localparam logic [7:0] ASCII_SPACE   = 8'd32;
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [7:0] PREV_RESET    = 8'd49;
  localparam logic [4:0] FILLER_CODE   = 5'd23;
  localparam logic [4:0] CODE_I        = 5'd8;
  localparam logic [4:0] CODE_J        = 5'd9;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_ROWS_01 = 2'd0;
  localparam logic [1:0] REG_KEY_ROWS_23 = 2'd1;
  localparam logic [1:0] REG_KEY_ROW_4   = 2'd2;

  // standard key square after reset
  localparam logic [49:0] KEY_ROWS_01_RESET = 50'd75020730666187;
  localparam logic [49:0] KEY_ROWS_23_RESET = 50'd367878684816948;
  localparam logic [24:0] KEY_ROW_4_RESET   = 25'd16374553;

  // key square, [row][column][code bit], cell 0 in the lowest bits
  typedef logic [4:0][4:0][4:0] key_sq_t;

  typedef struct packed {
    logic       lower;
    logic [4:0] code;
  } letter_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  // plaintext work for one request: up to two digraphs and a bad byte flag
  typedef struct packed {
    logic              bad;
    logic              msg_end;
    logic [1:0]        npairs;
    letter_t [3:0]     slots;
  } job_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       run_last;
    logic       msg_last;
    logic       bad;
  } result_t;

  // first cell in row-major order holding the code, j looked up as i
  function automatic pos_t find_cell(key_sq_t key, logic [4:0] code);
    logic [4:0] want;
    pos_t       pos;
    want = (code == CODE_J) ? CODE_I : code;
    pos  = '0;
    for (int r = 4; r >= 0; r--) begin
      for (int c = 4; c >= 0; c--) begin
        if (key[r][c] == want) begin
          pos.row = 3'(r);
          pos.col = 3'(c);
        end
      end
    end
    return pos;
  endfunction

  // step one place round the square
  function automatic logic [2:0] inc5(logic [2:0] x);
    return (x == 3'd4) ? 3'd0 : x + 3'd1;
  endfunction

  // playfair rule on one digraph, codes of both cipher letters
  function automatic logic [1:0][4:0] encipher(key_sq_t key, logic [4:0] a, logic [4:0] b);
    pos_t            p1;
    pos_t            p2;
    logic [1:0][4:0] o;
    p1 = find_cell(key, a);
    p2 = find_cell(key, b);
    if (p1.row == p2.row) begin
      o[0] = key[p1.row][inc5(p1.col)];
      o[1] = key[p2.row][inc5(p2.col)];
    end else if (p1.col == p2.col) begin
      o[0] = key[inc5(p1.row)][p1.col];
      o[1] = key[inc5(p2.row)][p2.col];
    end else begin
      o[0] = key[p1.row][p2.col];
      o[1] = key[p2.row][p1.col];
    end
    return o;
  endfunction

  // ascii byte of a letter code in the given case
  function automatic logic [7:0] letter_byte(logic [4:0] code, logic lower);
    return {3'b000, code} + (lower ? ASCII_LOWER_A : ASCII_UPPER_A);
  endfunction

endpackage

`default_nettype wire

>>> rtl/playfair_stream_encrypter.sv
// playfair stream encrypter: pairing, filler insertion and digraph encipherment
// depends on pfse_pkg
`default_nettype none
//
// text bytes enter on the in_ stream, one byte per request, in_tlast on the final
// byte of a message. spaces are dropped; a byte equal to the previous letter byte
// gets a lower-case x filler first; letters pair into digraphs that are enciphered
// through the 5x5 key square held in three configuration registers.
// each cipher letter leaves on the out_ stream with the case of its plain letter.
// a byte that is neither letter nor space gives one result with the bad flag set.
// one input byte gives zero to four results; out_tlast marks the last of them,
// out_tuser[0] the final letter of a message (odd length padded with x).
// each byte is held in the job register, then its results in the result buffer.
// throughput: a new byte may be taken every cycle while the job register is free
// or moving on to the result buffer; the output port moves one result a cycle
// while out_tready is high. the job register in front of the result buffer lets
// the next byte be taken while results of the previous one still wait.
// receiver stall: results hold on out_ and in_tready falls once both the job
// register and the result buffer are occupied.
// reset (rst_n low, synchronous): no letter held, no result pending and the key
// square back to the standard square. cfg_ writes are taken in every cycle.

module playfair_stream_encrypter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // stream_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] cipher_byte
  output logic             out_tlast,  // run_last
  output logic [1:0]       out_tuser,  // [0] message_last, [1] bad_byte
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [49:0] cfg_data
);

  // key square registers
  logic [49:0] key01_r;
  logic [49:0] key23_r;
  logic [24:0] key4_r;
  pfse_pkg::key_sq_t key_sq;

  // pairing state
  logic [4:0]  held_code_r,  held_code_nxt;
  logic        held_lower_r, held_lower_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [7:0]  prev_byte_r,  prev_byte_nxt;

  // job register and result buffer
  pfse_pkg::job_t         job_r, job_nxt;
  logic                   job_valid_r;
  pfse_pkg::result_t [3:0] res_r, res_build;
  logic [2:0]             res_cnt_r, res_build_cnt;

  // handshake
  logic in_acc, res_take, res_free, job_move;

  // front end decode
  logic        is_upper, is_lower, is_letter, is_space, rep;
  pfse_pkg::letter_t cur, filler;
  pfse_pkg::letter_t [3:0] slots;
  logic [2:0]  n;
  logic [1:0]  held_idx;

  // back end encipherment
  logic [1:0][4:0] ciph0, ciph1;
  logic [2:0]      k, k_last;

  assign key_sq = pfse_pkg::key_sq_t'({key4_r, key23_r, key01_r});

  // flow control between input, job register and result buffer
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (res_cnt_r != 3'd0);
  assign res_take   = out_tvalid && out_tready;
  assign res_free   = (res_cnt_r == 3'd0) || (res_take && (res_cnt_r == 3'd1));
  assign job_move   = job_valid_r && res_free;
  assign in_tready  = !job_valid_r || job_move;
  assign in_acc     = in_tvalid && in_tready;

  // result head
  assign out_tdata    = res_r[0].cipher_byte;
  assign out_tlast    = res_r[0].run_last;
  assign out_tuser[0] = res_r[0].msg_last;
  assign out_tuser[1] = res_r[0].bad;

  // classify the byte and lay out the letters in pairing order
  always_comb begin
    is_upper  = (in_tdata >= pfse_pkg::ASCII_UPPER_A) && (in_tdata <= pfse_pkg::ASCII_UPPER_Z);
    is_lower  = (in_tdata >= pfse_pkg::ASCII_LOWER_A) && (in_tdata <= pfse_pkg::ASCII_LOWER_Z);
    is_letter = is_upper || is_lower;
    is_space  = (in_tdata == pfse_pkg::ASCII_SPACE);
    rep       = is_letter && (in_tdata == prev_byte_r);
    cur.lower = is_lower;
    cur.code  = is_lower ? 5'(in_tdata - pfse_pkg::ASCII_LOWER_A)
                         : 5'(in_tdata - pfse_pkg::ASCII_UPPER_A);
    filler.lower = 1'b1;
    filler.code  = pfse_pkg::FILLER_CODE;
    slots = '0;
    n     = 3'd0;
    if (held_valid_r) begin
      slots[n[1:0]].code  = held_code_r;
      slots[n[1:0]].lower = held_lower_r;
      n = n + 3'd1;
    end
    if (is_letter) begin
      if (rep) begin
        slots[n[1:0]] = filler;
        n = n + 3'd1;
      end
      slots[n[1:0]] = cur;
      n = n + 3'd1;
    end
    // end of message: a lone letter is padded
    if (in_tlast && n[0]) begin
      slots[n[1:0]] = filler;
      n = n + 3'd1;
    end
    held_idx = n[1:0] - 2'd1;
  end

  // job for the back end and next pairing state
  always_comb begin
    job_nxt.bad     = !is_letter && !is_space;
    job_nxt.msg_end = in_tlast && (n[2:1] != 2'd0);
    job_nxt.npairs  = n[2:1];
    job_nxt.slots   = slots;
    held_code_nxt  = held_code_r;
    held_lower_nxt = held_lower_r;
    held_valid_nxt = held_valid_r;
    prev_byte_nxt  = prev_byte_r;
    if (in_tlast) begin
      held_code_nxt  = 5'd0;
      held_lower_nxt = 1'b0;
      held_valid_nxt = 1'b0;
      prev_byte_nxt  = pfse_pkg::PREV_RESET;
    end else begin
      if (is_letter) begin
        prev_byte_nxt = in_tdata;
      end
      held_valid_nxt = n[0];
      if (n[0]) begin
        held_code_nxt  = slots[held_idx].code;
        held_lower_nxt = slots[held_idx].lower;
      end
    end
  end

  // encipher both digraphs and build the result list
  always_comb begin
    ciph0 = pfse_pkg::encipher(key_sq, job_r.slots[0].code, job_r.slots[1].code);
    ciph1 = pfse_pkg::encipher(key_sq, job_r.slots[2].code, job_r.slots[3].code);
    res_build = '0;
    k = 3'd0;
    if (job_r.bad) begin
      res_build[k[1:0]].bad = 1'b1;
      k = k + 3'd1;
    end
    if (job_r.npairs != 2'd0) begin
      res_build[k[1:0]].cipher_byte = pfse_pkg::letter_byte(ciph0[0], job_r.slots[0].lower);
      k = k + 3'd1;
      res_build[k[1:0]].cipher_byte = pfse_pkg::letter_byte(ciph0[1], job_r.slots[1].lower);
      k = k + 3'd1;
    end
    if (job_r.npairs == 2'd2) begin
      res_build[k[1:0]].cipher_byte = pfse_pkg::letter_byte(ciph1[0], job_r.slots[2].lower);
      k = k + 3'd1;
      res_build[k[1:0]].cipher_byte = pfse_pkg::letter_byte(ciph1[1], job_r.slots[3].lower);
      k = k + 3'd1;
    end
    k_last = k - 3'd1;
    if (k != 3'd0) begin
      res_build[k_last[1:0]].run_last = 1'b1;
      res_build[k_last[1:0]].msg_last = job_r.msg_end;
    end
    res_build_cnt = k;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r <= pfse_pkg::KEY_ROWS_01_RESET;
      key23_r <= pfse_pkg::KEY_ROWS_23_RESET;
      key4_r  <= pfse_pkg::KEY_ROW_4_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfse_pkg::REG_KEY_ROWS_01: key01_r <= cfg_data;
        pfse_pkg::REG_KEY_ROWS_23: key23_r <= cfg_data;
        pfse_pkg::REG_KEY_ROW_4:   key4_r  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // pairing state and job register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_code_r  <= 5'd0;
      held_lower_r <= 1'b0;
      held_valid_r <= 1'b0;
      prev_byte_r  <= pfse_pkg::PREV_RESET;
      job_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        held_code_r  <= held_code_nxt;
        held_lower_r <= held_lower_nxt;
        held_valid_r <= held_valid_nxt;
        prev_byte_r  <= prev_byte_nxt;
        job_valid_r  <= 1'b1;
      end else if (job_move) begin
        job_valid_r  <= 1'b0;
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_r <= job_nxt;
    end
  end

  // result count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 3'd0;
    end else if (job_move) begin
      res_cnt_r <= res_build_cnt;
    end else if (res_take) begin
      res_cnt_r <= res_cnt_r - 3'd1;
    end
  end

  // result buffer, head at entry 0, shifts down as results leave
  always_ff @(posedge clk) begin
    if (job_move) begin
      res_r <= res_build;
    end else if (res_take) begin
      res_r <= {pfse_pkg::result_t'('0), res_r[3:1]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/pfse_checker.sv
// port-level checker for the playfair encrypter, bound to the top level
// depends on assert_macros.svh and playfair_stream_encrypter
`default_nettype none
`include "assert_macros.svh"

module pfse_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [1:0] out_tuser
);

  // a dropped byte report carries no letter
  `PFSE_ASSERT(a_bad_zero, clk, rst_n, (out_tvalid && out_tuser[1]) |-> (out_tdata == 8'd0), "bad byte result with nonzero data")

  // final letter of a message is always the last result of its byte
  `PFSE_ASSERT(a_msg_run, clk, rst_n, (out_tvalid && out_tuser[0]) |-> out_tlast, "message end without run end")

  // a dropped byte report is never the final letter
  `PFSE_ASSERT(a_bad_msg, clk, rst_n, (out_tvalid && out_tuser[1]) |-> !out_tuser[0], "bad byte flagged as message end")

  // input back-pressure only while results are waiting
  `PFSE_ASSERT(a_stall_src, clk, rst_n, !in_tready |-> out_tvalid, "input stalled with no pending result")

  // stalled result holds
  `PFSE_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)), "stalled result changed")

endmodule

bind playfair_stream_encrypter pfse_checker u_pfse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> tb/tb.sv
// self-checking bench for playfair_stream_encrypter: text requests with random idling,
// results checked field by field against an in-bench playfair predictor
// depends on pfse_pkg and playfair_stream_encrypter
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 40;
  // index beyond the three key registers, writes to it change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] text;
    logic       fin;
  } plain_req_t;

  typedef struct packed {
    logic [7:0] cipher;
    logic       run_end;
    logic       msg_end;
    logic       bad;
  } cipher_res_t;

  // dut ports, every input known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [49:0] cfg_data   = '0;

  // stimulus and expectation stores
  plain_req_t  plain_q[$];
  cipher_res_t cipher_due[$];
  cipher_res_t step_out[$];
  int          step_letter;

  // predictor copy of the key square and pairing state
  logic [49:0] sq_rows01   = pfse_pkg::KEY_ROWS_01_RESET;
  logic [49:0] sq_rows23   = pfse_pkg::KEY_ROWS_23_RESET;
  logic [24:0] sq_row4     = pfse_pkg::KEY_ROW_4_RESET;
  logic [4:0]  pend_code   = '0;
  logic        pend_lower  = 1'b0;
  logic        pend_valid  = 1'b0;
  logic [7:0]  last_text   = pfse_pkg::PREV_RESET;

  // bench bookkeeping
  logic [7:0]  last_plain  = "a";
  logic        in_taken    = 1'b0;
  int          in_gap      = 0;
  int          out_hold    = 0;
  int          calm_in     = 0;
  int          calm_out    = 0;
  int          errors      = 0;
  int          cycles      = 0;

  playfair_stream_encrypter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // letter code held in one cell of the square, row-major
  function automatic logic [4:0] sq_cell(int idx);
    if (idx < 10) return sq_rows01[5*idx +: 5];
    if (idx < 20) return sq_rows23[5*(idx-10) +: 5];
    return sq_row4[5*(idx-20) +: 5];
  endfunction

  // first cell holding the letter, j searched as i, cell 0 when absent
  function automatic int sq_locate(logic [4:0] code);
    logic [4:0] want;
    want = (code == pfse_pkg::CODE_J) ? pfse_pkg::CODE_I : code;
    for (int i = 0; i < 25; i++)
      if (sq_cell(i) == want) return i;
    return 0;
  endfunction

  task automatic emit_letter(logic [4:0] code, logic lower);
    cipher_res_t res;
    res = '0;
    res.cipher = {3'b000, code} + (lower ? pfse_pkg::ASCII_LOWER_A : pfse_pkg::ASCII_UPPER_A);
    step_letter = step_out.size();
    step_out = {step_out, res};
  endtask

  task automatic encipher_pair(logic [4:0] a, logic la, logic [4:0] b, logic lb);
    int p1, p2, r1, c1, r2, c2;
    logic [4:0] o1, o2;
    p1 = sq_locate(a);
    p2 = sq_locate(b);
    r1 = p1 / 5;
    c1 = p1 % 5;
    r2 = p2 / 5;
    c2 = p2 % 5;
    // same row moves right, same column moves down, else swap corners
    if (r1 == r2) begin
      o1 = sq_cell(r1*5 + (c1+1)%5);
      o2 = sq_cell(r2*5 + (c2+1)%5);
    end else if (c1 == c2) begin
      o1 = sq_cell(((r1+1)%5)*5 + c1);
      o2 = sq_cell(((r2+1)%5)*5 + c2);
    end else begin
      o1 = sq_cell(r1*5 + c2);
      o2 = sq_cell(r2*5 + c1);
    end
    emit_letter(o1, la);
    emit_letter(o2, lb);
  endtask

  task automatic take_letter(logic [4:0] code, logic lower);
    if (!pend_valid) begin
      pend_code  = code;
      pend_lower = lower;
      pend_valid = 1'b1;
    end else begin
      encipher_pair(pend_code, pend_lower, code, lower);
      pend_valid = 1'b0;
    end
  endtask

  // expected results of one accepted text request
  task automatic predict_plain(logic [7:0] b, logic fin);
    cipher_res_t res;
    logic        lower;
    step_out.delete();
    step_letter = -1;
    if (b == pfse_pkg::ASCII_SPACE) begin
      // spaces leave no trace
    end else if ((b >= pfse_pkg::ASCII_UPPER_A && b <= pfse_pkg::ASCII_UPPER_Z) ||
                 (b >= pfse_pkg::ASCII_LOWER_A && b <= pfse_pkg::ASCII_LOWER_Z)) begin
      lower = (b >= pfse_pkg::ASCII_LOWER_A);
      // repeated raw byte gets a lower-case x in front
      if (b == last_text) take_letter(pfse_pkg::FILLER_CODE, 1'b1);
      take_letter(5'(b - (lower ? pfse_pkg::ASCII_LOWER_A : pfse_pkg::ASCII_UPPER_A)), lower);
      last_text = b;
    end else begin
      res     = '0;
      res.bad = 1'b1;
      step_out = {step_out, res};
    end
    // end of message: pad a lone letter, then clear the pairing state
    if (fin) begin
      if (pend_valid) take_letter(pfse_pkg::FILLER_CODE, 1'b1);
      if (step_letter >= 0) step_out[step_letter].msg_end = 1'b1;
      pend_code  = '0;
      pend_lower = 1'b0;
      pend_valid = 1'b0;
      last_text  = pfse_pkg::PREV_RESET;
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].run_end = 1'b1;
    cipher_due = {cipher_due, step_out};
  endtask

  // ---------------------------------------------------------------- helpers

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // idle length: mostly none or short, a few long, now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  task automatic queue_text(logic [7:0] b, logic fin);
    plain_req_t req;
    req.text = b;
    req.fin  = fin;
    plain_q = {plain_q, req};
  endtask

  // mostly letters with repeats, some spaces and stray bytes
  task automatic queue_random(int n);
    int         r;
    logic [7:0] b;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 12) b = last_plain;
      else if (r < 22) b = pfse_pkg::ASCII_SPACE;
      else if (r < 32) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(0, 25)) +
               ($urandom_range(0, 1) ? pfse_pkg::ASCII_LOWER_A : pfse_pkg::ASCII_UPPER_A);
      if ((b >= pfse_pkg::ASCII_UPPER_A && b <= pfse_pkg::ASCII_UPPER_Z) ||
          (b >= pfse_pkg::ASCII_LOWER_A && b <= pfse_pkg::ASCII_LOWER_Z)) last_plain = b;
      queue_text(b, $urandom_range(0, 9) == 0);
    end
  endtask

  // register write, predictor follows once the request is taken
  task automatic write_key(logic [1:0] idx, logic [49:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pfse_pkg::REG_KEY_ROWS_01: sq_rows01 = val;
      pfse_pkg::REG_KEY_ROWS_23: sq_rows23 = val;
      pfse_pkg::REG_KEY_ROW_4:   sq_row4   = val[24:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // well-formed square: 25 distinct letters, one random letter left out
  task automatic random_square();
    logic [4:0]  pool[$];
    logic [49:0] rows01, rows23;
    logic [24:0] row4;
    int          k;
    for (int c = 0; c < 26; c++) pool = {pool, 5'(c)};
    pool.delete($urandom_range(0, 25));
    for (int i = 0; i < 25; i++) begin
      k = $urandom_range(0, pool.size() - 1);
      if (i < 10) rows01[5*i +: 5] = pool[k];
      else if (i < 20) rows23[5*(i-10) +: 5] = pool[k];
      else row4[5*(i-20) +: 5] = pool[k];
      pool.delete(k);
    end
    write_key(pfse_pkg::REG_KEY_ROWS_01, rows01);
    write_key(pfse_pkg::REG_KEY_ROWS_23, rows23);
    write_key(pfse_pkg::REG_KEY_ROW_4, {25'd0, row4});
  endtask

  // all requests taken and every result back, then a few quiet cycles
  task automatic wait_idle();
    int spent, quiet;
    spent = 0;
    quiet = 0;
    while (plain_q.size() > 0 || in_tvalid) @(posedge clk);
    while (quiet < SETTLE_CYCLES && spent < DRAIN_LIMIT) begin
      @(posedge clk);
      spent++;
      if (cipher_due.size() == 0) quiet++;
      else quiet = 0;
    end
    if (cipher_due.size() > 0) begin
      report_mismatch("results never delivered", cipher_due.size(), 0);
      cipher_due.delete();
    end
  endtask

  // ---------------------------------------------------------------- driver

  // text requests change on the falling edge
  always @(negedge clk) begin
    plain_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (plain_q.size() > 0) begin
        req = plain_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.text;
        in_tlast  <= req.fin;
        in_gap    = pick_gap(calm_in);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls at random points
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_hold = ($urandom_range(0, 3) == 0) ? pick_gap(calm_out) : 0;
      if (out_hold > 0) begin
        out_tready <= 1'b0;
        out_hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    cipher_res_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_plain(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (cipher_due.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = cipher_due.pop_front();
          if (out_tdata !== want.cipher)
            report_mismatch("cipher_byte", out_tdata, want.cipher);
          if (out_tlast !== want.run_end)
            report_mismatch("run_last", out_tlast, want.run_end);
          if (out_tuser[0] !== want.msg_end)
            report_mismatch("message_last", out_tuser[0], want.msg_end);
          if (out_tuser[1] !== want.bad)
            report_mismatch("bad_byte", out_tuser[1], want.bad);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** playfair_stream_encrypter: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- phases

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed requests on the standard square
    queue_text("A", 1'b0);   queue_text("Z", 1'b0);
    queue_text("a", 1'b0);   queue_text("z", 1'b0);
    // j and i share a cell
    queue_text("J", 1'b0);   queue_text("I", 1'b0);
    // doubled letter, then the same letter in the other case
    queue_text("l", 1'b0);   queue_text("l", 1'b0);   queue_text("L", 1'b0);
    // bytes just outside both letter ranges and the byte extremes
    queue_text("@", 1'b0);   queue_text("[", 1'b0);
    queue_text(8'h60, 1'b0); queue_text("{", 1'b0);
    queue_text(8'h00, 1'b0); queue_text(8'hff, 1'b0);
    // repeat across a space, closed by the message end: four results
    queue_text(" ", 1'b0);   queue_text("q", 1'b0);
    queue_text(" ", 1'b0);   queue_text("q", 1'b1);
    // message end with nothing held
    queue_text(" ", 1'b1);
    // bad byte ahead of the padding
    queue_text("m", 1'b0);   queue_text("#", 1'b1);
    // doubled filler letter itself
    queue_text("x", 1'b0);   queue_text("x", 1'b1);
    // lone letter padded
    queue_text("K", 1'b1);
    wait_idle();

    // well-formed square
    random_square();
    queue_random(110);
    wait_idle();

    // every cell letter a: most letters missing from the square
    write_key(pfse_pkg::REG_KEY_ROWS_01, '0);
    write_key(pfse_pkg::REG_KEY_ROWS_23, '0);
    write_key(pfse_pkg::REG_KEY_ROW_4, '0);
    queue_random(30);
    wait_idle();

    // every cell out of the alphabet, plus the unused index
    write_key(pfse_pkg::REG_KEY_ROWS_01, '1);
    write_key(pfse_pkg::REG_KEY_ROWS_23, '1);
    write_key(pfse_pkg::REG_KEY_ROW_4, '1);
    write_key(REG_SPARE, 50'({$urandom, $urandom}));
    queue_random(30);
    wait_idle();

    // raw random cell codes
    write_key(pfse_pkg::REG_KEY_ROWS_01, 50'({$urandom, $urandom}));
    write_key(pfse_pkg::REG_KEY_ROWS_23, 50'({$urandom, $urandom}));
    write_key(pfse_pkg::REG_KEY_ROW_4, 50'({$urandom, $urandom}));
    queue_random(40);
    wait_idle();

    random_square();
    queue_random(120);
    wait_idle();

    // back to the standard square
    write_key(pfse_pkg::REG_KEY_ROWS_01, pfse_pkg::KEY_ROWS_01_RESET);
    write_key(pfse_pkg::REG_KEY_ROWS_23, pfse_pkg::KEY_ROWS_23_RESET);
    write_key(pfse_pkg::REG_KEY_ROW_4, {25'd0, pfse_pkg::KEY_ROW_4_RESET});
    queue_random(70);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("** playfair_stream_encrypter: PASSED **");
    else $display("** playfair_stream_encrypter: FAILED **");
    $finish;
  end

endmodule
